### design/stdq_pkg.sv
// ----------------------------------------------------------------------------
// stdq_pkg
// Types and constants shared by the stereo TPDF dither quantizer.
// ----------------------------------------------------------------------------
package stdq_pkg;

    // Generator seed that is used after reset and whenever a zero seed is written.
    localparam logic [31:0] SEED_DEFAULT = 32'h1234_5678;

    // Full scale of the input format (1.0 = 2^23).
    localparam int FS_SHIFT = 23;
    // Largest peak magnitude that the peak fields can report.
    localparam logic [22:0] PEAK_MAX = 23'h7F_FFFF;

    typedef struct packed {
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic               mute;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic [22:0]        peak_left;
        logic [22:0]        peak_right;
    } t_out_item;

    // Clamped channel value after the dither has been added, held as sign and magnitude.
    typedef struct packed {
        logic        neg;
        logic [23:0] mag;
    } t_chan_mag;

    typedef struct packed {
        t_chan_mag left;
        t_chan_mag right;
    } t_mid_item;

endpackage

### design/stdq_prng.sv
// ----------------------------------------------------------------------------
// stdq_prng
// Xorshift32 generator that advances four steps per accepted item and
// provides the triangular dither for the left and right channels.
// ----------------------------------------------------------------------------
module stdq_prng (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_advance,
    output logic signed [16:0] o_dither_left,
    output logic signed [16:0] o_dither_right
);

    logic [31:0] r_state;
    logic [31:0] n_state;
    logic [31:0] w_s1;
    logic [31:0] w_s2;
    logic [31:0] w_s3;
    logic [31:0] w_s4;

    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    assign w_s1 = xs_step(r_state);
    assign w_s2 = xs_step(w_s1);
    assign w_s3 = xs_step(w_s2);
    assign w_s4 = xs_step(w_s3);

    // The 0x8000 offsets of the two uniform values cancel in their difference.
    assign o_dither_left  = $signed({1'b0, w_s1[15:0]}) - $signed({1'b0, w_s2[15:0]});
    assign o_dither_right = $signed({1'b0, w_s3[15:0]}) - $signed({1'b0, w_s4[15:0]});

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = (i_cfg_data == 32'd0) ? stdq_pkg::SEED_DEFAULT : i_cfg_data;
        end else if (i_advance) begin
            n_state = w_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stdq_pkg::SEED_DEFAULT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/stdq_clamp.sv
// ----------------------------------------------------------------------------
// stdq_clamp
// Adds the dither to one channel sample and clamps the exact sum to
// plus or minus full scale, giving sign and magnitude.
// ----------------------------------------------------------------------------
module stdq_clamp (
    input  logic signed [31:0]  i_sample,
    input  logic signed [16:0]  i_dither,
    output stdq_pkg::t_chan_mag o_chan
);

    localparam logic signed [32:0] FS_POS = 33'sd8388608;
    localparam logic signed [32:0] FS_NEG = -33'sd8388608;

    logic signed [32:0] w_sum;
    logic signed [32:0] w_neg_sum;

    assign w_sum     = 33'(i_sample) + 33'(i_dither);
    assign w_neg_sum = -w_sum;

    always_comb begin
        if (w_sum > FS_POS) begin
            o_chan.neg = 1'b0;
            o_chan.mag = 24'h80_0000;
        end else if (w_sum < FS_NEG) begin
            o_chan.neg = 1'b1;
            o_chan.mag = 24'h80_0000;
        end else begin
            o_chan.neg = w_sum[32];
            o_chan.mag = w_sum[32] ? w_neg_sum[23:0] : w_sum[23:0];
        end
    end

endmodule

### design/stdq_scale.sv
// ----------------------------------------------------------------------------
// stdq_scale
// Scales a clamped magnitude to the output full scale with truncation and
// forms the signed 24-bit output word and the saturated peak magnitude.
// ----------------------------------------------------------------------------
module stdq_scale #(
    parameter int OUT_BITS = 24
) (
    input  stdq_pkg::t_chan_mag i_chan,
    output logic signed [23:0]  o_word,
    output logic [22:0]         o_mag
);

    localparam int PW = 24 + OUT_BITS - 1;

    logic [PW-1:0]       w_prod;
    logic [OUT_BITS-1:0] w_scaled;
    logic [32:0]         w_wide;
    logic [32:0]         w_neg_wide;

    // mag * (2^(OUT_BITS-1) - 1) as a shift and a subtract.
    assign w_prod     = {i_chan.mag, {(OUT_BITS-1){1'b0}}} - PW'(i_chan.mag);
    assign w_scaled   = w_prod[PW-1:stdq_pkg::FS_SHIFT];
    assign w_wide     = 33'(w_scaled);
    assign w_neg_wide = 33'd0 - w_wide;

    assign o_word = i_chan.neg ? w_neg_wide[23:0] : w_wide[23:0];
    assign o_mag  = (w_wide > 33'(stdq_pkg::PEAK_MAX)) ? stdq_pkg::PEAK_MAX : w_wide[22:0];

endmodule

### design/stereo_tpdf_dither_quantizer.sv
// ----------------------------------------------------------------------------
// stereo_tpdf_dither_quantizer
// Stereo TPDF dither, clamp and requantization with running peak hold.
// ----------------------------------------------------------------------------
// One stereo item is taken per clock unless o_stall is high. The pipeline has
// an input stage (dither generation, sum and clamp) and the result
// register (scaling and peak update), and each stage holds while the
// output is stalled, so up to two items can be in flight. The dither
// generator advances four xorshift32 steps for every accepted item, muted or
// not. Writing the seed reloads the generator (zero loads 0x12345678) and
// must happen while no item is in flight. Peak fields report the largest
// output magnitude since reset, including the item they travel with.
module stereo_tpdf_dither_quantizer #(
    parameter int OUT_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  stdq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output stdq_pkg::t_out_item o_item
);

    logic                r_s1_valid;
    logic                n_s1_valid;
    stdq_pkg::t_mid_item r_s1;
    stdq_pkg::t_mid_item n_s1;
    logic                r_out_valid;
    logic                n_out_valid;
    stdq_pkg::t_out_item r_out;
    stdq_pkg::t_out_item n_out;

    logic                w_out_free;
    logic                w_s1_free;
    logic                w_accept;
    logic                w_s2_go;
    logic signed [16:0]  w_dither_left;
    logic signed [16:0]  w_dither_right;
    logic signed [31:0]  w_left_in;
    logic signed [31:0]  w_right_in;
    stdq_pkg::t_chan_mag w_left_chan;
    stdq_pkg::t_chan_mag w_right_chan;
    logic signed [23:0]  w_left_word;
    logic signed [23:0]  w_right_word;
    logic [22:0]         w_left_mag;
    logic [22:0]         w_right_mag;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign w_accept   = i_valid && w_s1_free;
    assign w_s2_go    = r_s1_valid && w_out_free;

    assign o_stall = !w_s1_free;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    stdq_prng u_prng (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_advance      (w_accept),
        .o_dither_left  (w_dither_left),
        .o_dither_right (w_dither_right)
    );

    assign w_left_in  = i_item.mute ? 32'sd0 : i_item.left_sample;
    assign w_right_in = i_item.mute ? 32'sd0 : i_item.right_sample;

    stdq_clamp u_clamp_left (
        .i_sample (w_left_in),
        .i_dither (w_dither_left),
        .o_chan   (w_left_chan)
    );

    stdq_clamp u_clamp_right (
        .i_sample (w_right_in),
        .i_dither (w_dither_right),
        .o_chan   (w_right_chan)
    );

    stdq_scale #(.OUT_BITS(OUT_BITS)) u_scale_left (
        .i_chan (r_s1.left),
        .o_word (w_left_word),
        .o_mag  (w_left_mag)
    );

    stdq_scale #(.OUT_BITS(OUT_BITS)) u_scale_right (
        .i_chan (r_s1.right),
        .o_word (w_right_word),
        .o_mag  (w_right_mag)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (w_s1_free) begin
            n_s1_valid = i_valid;
            n_s1.left  = w_left_chan;
            n_s1.right = w_right_chan;
        end
    end

    // The result register doubles as the peak hold: it only loads when the
    // previous result has left, so its peaks always belong to the item shown.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_free) begin
            n_out_valid = r_s1_valid;
        end
        if (w_s2_go) begin
            n_out.left_out  = w_left_word;
            n_out.right_out = w_right_word;
            if (w_left_mag > r_out.peak_left) begin
                n_out.peak_left = w_left_mag;
            end
            if (w_right_mag > r_out.peak_right) begin
                n_out.peak_right = w_right_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // Peak hold never decreases once out of reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_out.peak_left >= $past(r_out.peak_left))
                        && (r_out.peak_right >= $past(r_out.peak_right)))
        else $error("peak hold decreased");

    // Input is only stalled when both pipeline stages are occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // A blocked first stage keeps its item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> (r_s1_valid && $stable(r_s1)))
        else $error("first stage lost or changed a blocked item");

endmodule

### verif/tb_stereo_tpdf_dither_quantizer.sv
// ----------------------------------------------------------------------------
// tb_stereo_tpdf_dither_quantizer
// Self-checking bench for the stereo TPDF dither quantizer. A directed table
// covers mute, zero, small values, full-scale clamping and sign extremes. It is
// followed by random stereo items under several dither seeds and several idle
// patterns on both sides. Every result is compared with a predictor that keeps
// its own xorshift32 generator and its own peak holds, or with a fixed table value.
// ----------------------------------------------------------------------------
module tb_stereo_tpdf_dither_quantizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W          = 24;
    localparam int STALL_LIMIT    = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic signed [23:0] OUT_POS_MAX = 24'sd8388607;
    localparam logic signed [23:0] OUT_NEG_MAX = -24'sd8388607;

    typedef struct {
        stdq_pkg::t_in_item  pair;
        bit                  fixed;
        stdq_pkg::t_out_item want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [31:0]         i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    stdq_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_stall;
    stdq_pkg::t_out_item o_item;

    // Predictor state.
    logic [31:0] gen_state;
    logic [22:0] hold_peak_l;
    logic [22:0] hold_peak_r;

    stdq_pkg::t_out_item expected_words[$];
    t_dir_row            dir_rows[$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int quiet_cycles  = 0;

    stereo_tpdf_dither_quantizer #(
        .OUT_BITS(OUT_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] xorshift_next(logic [31:0] s);
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        return s;
    endfunction

    // Two generator steps give one triangular dither value.
    function automatic longint tpdf_draw();
        longint r1;
        longint r2;
        gen_state = xorshift_next(gen_state);
        r1 = longint'(gen_state[15:0]) - 32'h8000;
        gen_state = xorshift_next(gen_state);
        r2 = longint'(gen_state[15:0]) - 32'h8000;
        return r1 - r2;
    endfunction

    function automatic logic [OUT_W-1:0] scale_channel(longint x, output logic [22:0] mag_sat);
        longint full;
        longint fs;
        longint mag;
        bit     neg;
        full = longint'(1) << stdq_pkg::FS_SHIFT;
        fs   = (longint'(1) << (OUT_W - 1)) - 1;
        if (x > full)
            x = full;
        if (x < -full)
            x = -full;
        neg = x < 0;
        mag = neg ? -x : x;
        mag = (mag * fs) >>> stdq_pkg::FS_SHIFT;
        mag_sat = (mag > longint'(stdq_pkg::PEAK_MAX)) ? stdq_pkg::PEAK_MAX : mag[22:0];
        return neg ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    function automatic stdq_pkg::t_out_item quantize_pair(stdq_pkg::t_in_item it);
        stdq_pkg::t_out_item res;
        longint              l;
        longint              r;
        logic [22:0]         ml;
        logic [22:0]         mr;
        l = it.mute ? 0 : longint'(it.left_sample);
        r = it.mute ? 0 : longint'(it.right_sample);
        l += tpdf_draw();
        r += tpdf_draw();
        res.left_out  = scale_channel(l, ml);
        res.right_out = scale_channel(r, mr);
        if (ml > hold_peak_l)
            hold_peak_l = ml;
        if (mr > hold_peak_r)
            hold_peak_r = mr;
        res.peak_left  = hold_peak_l;
        res.peak_right = hold_peak_r;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return int'($urandom_range(16777216)) - 8388608;
            4, 5:       return int'($urandom_range(140000)) - 70000;
            6, 7:       return $urandom;
            8:          return 8388608 + int'($urandom_range(140000)) - 70000;
            default:    return -8388608 + int'($urandom_range(140000)) - 70000;
        endcase
    endfunction

    task automatic add_row(input logic [31:0] l, input logic [31:0] r, input logic m,
                           input bit fixed, input logic signed [23:0] lo,
                           input logic signed [23:0] ro);
        t_dir_row row;
        row.pair.left_sample  = l;
        row.pair.right_sample = r;
        row.pair.mute         = m;
        row.fixed             = fixed;
        row.want.left_out     = lo;
        row.want.right_out    = ro;
        row.want.peak_left    = stdq_pkg::PEAK_MAX;
        row.want.peak_right   = stdq_pkg::PEAK_MAX;
        dir_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is
    // taken, leaving i_valid for the caller to set.
    task automatic send_pair(input stdq_pkg::t_in_item it, input bit fixed,
                             input stdq_pkg::t_out_item want);
        stdq_pkg::t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do
            @(posedge i_clk);
        while (o_stall);
        pred = quantize_pair(it);
        expected_words.push_back(fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        while (expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= seed;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        gen_state = (seed != 32'd0) ? seed : stdq_pkg::SEED_DEFAULT;
    endtask

    task automatic run_random(input int count);
        stdq_pkg::t_in_item  it;
        stdq_pkg::t_out_item none;
        none = '0;
        repeat (count) begin
            it.left_sample  = rand_sample();
            it.right_sample = rand_sample();
            it.mute         = ($urandom_range(9) == 0);
            send_pair(it, 1'b0, none);
        end
        i_valid <= 1'b0;
    endtask

    // Receiver side: random stall, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        stdq_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result item: %p", o_item);
                err_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_item.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d", want.left_out, o_item.left_out);
                    err_count++;
                end
                if (o_item.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d", want.right_out,
                           o_item.right_out);
                    err_count++;
                end
                if (o_item.peak_left !== want.peak_left) begin
                    $error("peak_left: expected %0d, got %0d", want.peak_left,
                           o_item.peak_left);
                    err_count++;
                end
                if (o_item.peak_right !== want.peak_right) begin
                    $error("peak_right: expected %0d, got %0d", want.peak_right,
                           o_item.peak_right);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_item     = '0;
        gen_state   = stdq_pkg::SEED_DEFAULT;
        hold_peak_l = '0;
        hold_peak_r = '0;

        // Small magnitudes first so the peak holds climb before the clamp rows.
        add_row(32'd0, 32'd0, 1'b1, 1'b0, '0, '0);
        add_row(32'd0, 32'd0, 1'b0, 1'b0, '0, '0);
        add_row(-32'sd1, 32'sd1, 1'b0, 1'b0, '0, '0);
        add_row(32'sd12345, -32'sd54321, 1'b0, 1'b0, '0, '0);
        add_row(32'sd65535, -32'sd65535, 1'b0, 1'b0, '0, '0);
        add_row(32'sd4194304, -32'sd4194304, 1'b0, 1'b0, '0, '0);
        add_row(32'sd8388607, -32'sd8388607, 1'b0, 1'b0, '0, '0);
        add_row(32'sd8388608, -32'sd8388608, 1'b0, 1'b0, '0, '0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0, '0);
        // Far beyond full scale the dither cannot escape the clamp.
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, OUT_POS_MAX, OUT_NEG_MAX);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, OUT_NEG_MAX, OUT_POS_MAX);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, OUT_POS_MAX, OUT_NEG_MAX);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1, OUT_NEG_MAX, OUT_POS_MAX);
        add_row(32'h00FF_FFFF, 32'hFF00_0001, 1'b0, 1'b1, OUT_POS_MAX, OUT_NEG_MAX);
        add_row(32'sd8454144, -32'sd8454144, 1'b0, 1'b1, OUT_POS_MAX, OUT_NEG_MAX);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, '0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 78;
        foreach (dir_rows[k])
            send_pair(dir_rows[k].pair, dir_rows[k].fixed, dir_rows[k].want);
        i_valid <= 1'b0;

        // A zero seed must fall back to the default generator state.
        load_seed(32'd0);
        run_random(400);

        send_idle_pct = 78;
        recv_idle_pct = 34;
        load_seed(32'hFFFF_FFFF);
        run_random(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_seed($urandom);
        hold_req = HOLD_CYCLES;
        run_random(300);

        load_seed(32'd1);
        run_random(150);

        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
